FILE: rtl/tms_pkg.sv
`default_nettype none
package tms_pkg;

  localparam int CW = 20;
  localparam int IW = 19;
  localparam int TNW = 16;
  localparam int NUM_LANES = 6;
  localparam int NUM_BEATS = 10;
  localparam int NUM_VERTS = 6;
  localparam int COORD_MAX = 524287;
  localparam int MAX_TRIANGLES_DEF = 65536;
  localparam int FRAC_BITS_DEF = 16;
  localparam int IN_DW = 200;
  localparam int OUT_DW = 136;

  typedef logic [2:0][CW-1:0] vec_t;

  typedef struct packed {
    logic start;
    logic ack;
    logic norm_en;
  } lane_ctl_t;

  // corner offsets of faces ADE, BFD, CEF, DFE
  localparam logic [2:0] FACE_TBL [4][3] = '{
    '{3'd1, 3'd4, 3'd5},
    '{3'd2, 3'd6, 3'd4},
    '{3'd3, 3'd5, 3'd6},
    '{3'd4, 3'd6, 3'd5}
  };

endpackage
`default_nettype wire

FILE: rtl/tms_lane.sv
`default_nettype none
module tms_lane #(
  parameter int FRAC_BITS = tms_pkg::FRAC_BITS_DEF
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  tms_pkg::lane_ctl_t ctl_i,
  input  tms_pkg::vec_t      vec_i,
  output logic               done_o,
  output tms_pkg::vec_t      vec_o
);
  import tms_pkg::*;

  localparam int SW = 2 * CW;
  localparam int RW = CW;
  localparam int SREM_W = RW + 2;
  localparam int QW = FRAC_BITS + 1;
  localparam int QP = 2 * ((QW + 1) / 2);
  localparam int DW = CW + FRAC_BITS;
  localparam int SQ_CYC = RW / 2;
  localparam int DIV_CYC = QP / 2;
  localparam int MAXC = (SQ_CYC > DIV_CYC) ? SQ_CYC : DIV_CYC;
  localparam int CNT_W = $clog2(MAXC + 1);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SQR  = 7'b0000010,
    ST_SUM  = 7'b0000100,
    ST_ROOT = 7'b0001000,
    ST_DIV  = 7'b0010000,
    ST_FIN  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   cnt_q;
  vec_t               vin_q, res_q;
  logic [CW-1:0]      mag_q [3];
  logic [SW-1:0]      sq_q [3];
  logic [SW-1:0]      s_q, s_d;
  logic [RW-1:0]      root_q, root_d;
  logic [SREM_W-1:0]  srem_q, srem_d;
  logic [RW-1:0]      drem_q [3], drem_d [3];
  logic [QP-1:0]      dbits_q [3], dbits_d [3];
  logic [QP-1:0]      quo_q [3], quo_d [3];
  logic [CW-1:0]      mag_c [3];
  vec_t               fin_c;

  always_comb begin
    logic [SW-1:0]     s_v;
    logic [RW-1:0]     root_v;
    logic [SREM_W-1:0] srem_v;
    logic [SREM_W+1:0] t_v, trial_v;
    s_v = s_q;
    root_v = root_q;
    srem_v = srem_q;
    for (int i = 0; i < 2; i++) begin
      t_v = {srem_v, s_v[SW-1 -: 2]};
      trial_v = {{(SREM_W - RW){1'b0}}, root_v, 2'b01};
      if (t_v >= trial_v) begin
        srem_v = SREM_W'(t_v - trial_v);
        root_v = {root_v[RW-2:0], 1'b1};
      end else begin
        srem_v = t_v[SREM_W-1:0];
        root_v = {root_v[RW-2:0], 1'b0};
      end
      s_v = {s_v[SW-3:0], 2'b00};
    end
    s_d = s_v;
    root_d = root_v;
    srem_d = srem_v;
  end

  always_comb begin
    logic [RW-1:0] rem_v;
    logic [QP-1:0] bits_v, quo_v;
    logic [RW:0]   t_v;
    for (int j = 0; j < 3; j++) begin
      rem_v = drem_q[j];
      bits_v = dbits_q[j];
      quo_v = quo_q[j];
      for (int i = 0; i < 2; i++) begin
        t_v = {rem_v, bits_v[QP-1]};
        if (t_v >= {1'b0, root_q}) begin
          rem_v = RW'(t_v - {1'b0, root_q});
          quo_v = {quo_v[QP-2:0], 1'b1};
        end else begin
          rem_v = t_v[RW-1:0];
          quo_v = {quo_v[QP-2:0], 1'b0};
        end
        bits_v = {bits_v[QP-2:0], 1'b0};
      end
      drem_d[j] = rem_v;
      dbits_d[j] = bits_v;
      quo_d[j] = quo_v;
    end
  end

  always_comb begin
    logic [IW-1:0] mq;
    for (int j = 0; j < 3; j++) begin
      mag_c[j] = vec_i[j][CW-1] ? CW'(-vec_i[j]) : vec_i[j];
      mq = (32'(quo_q[j]) > COORD_MAX) ? IW'(COORD_MAX) : IW'(quo_q[j]);
      if (root_q == '0) begin
        fin_c[j] = '0;
      end else if (vin_q[j][CW-1]) begin
        fin_c[j] = CW'(-{1'b0, mq});
      end else begin
        fin_c[j] = {1'b0, mq};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (ctl_i.start) state_q <= ctl_i.norm_en ? ST_SQR : ST_DONE;
        end
        ST_SQR: state_q <= ST_SUM;
        ST_SUM: begin
          state_q <= ST_ROOT;
          cnt_q <= '0;
        end
        ST_ROOT: begin
          if (cnt_q == CNT_W'(SQ_CYC - 1)) begin
            state_q <= ST_DIV;
            cnt_q <= '0;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_DIV: begin
          if (cnt_q == CNT_W'(DIV_CYC - 1)) begin
            state_q <= ST_FIN;
            cnt_q <= '0;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_FIN: state_q <= ST_DONE;
        ST_DONE: begin
          if (ctl_i.ack) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    logic [DW-1:0] n_v;
    case (state_q)
      ST_IDLE: begin
        if (ctl_i.start) begin
          vin_q <= vec_i;
          res_q <= vec_i;
          for (int j = 0; j < 3; j++) begin
            mag_q[j] <= mag_c[j];
            n_v = {mag_c[j], {FRAC_BITS{1'b0}}};
            drem_q[j] <= RW'(n_v >> QP);
            dbits_q[j] <= n_v[QP-1:0];
            quo_q[j] <= '0;
          end
        end
      end
      ST_SQR: begin
        for (int j = 0; j < 3; j++) sq_q[j] <= mag_q[j] * mag_q[j];
      end
      ST_SUM: begin
        s_q <= sq_q[0] + sq_q[1] + sq_q[2];
        root_q <= '0;
        srem_q <= '0;
      end
      ST_ROOT: begin
        s_q <= s_d;
        root_q <= root_d;
        srem_q <= srem_d;
      end
      ST_DIV: begin
        for (int j = 0; j < 3; j++) begin
          drem_q[j] <= drem_d[j];
          dbits_q[j] <= dbits_d[j];
          quo_q[j] <= quo_d[j];
        end
      end
      ST_FIN: res_q <= fin_c;
      default: ;
    endcase
  end

  assign done_o = (state_q == ST_DONE);
  assign vec_o = res_q;

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("lane state not one-hot");
  a_root_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROOT && cnt_q == CNT_W'(SQ_CYC - 1)) |=> state_q == ST_DIV)
    else $error("root phase overran");
  a_zero_vec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && root_q == '0) |=> res_q == '0)
    else $error("zero vector not mapped to zero");

endmodule
`default_nettype wire

FILE: rtl/tms_merge.sv
`default_nettype none
module tms_merge (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                load_i,
  input  tms_pkg::vec_t                      verts_i [tms_pkg::NUM_VERTS],
  input  wire  [tms_pkg::IW-1:0]             base_i,
  output logic                               ready_o,
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // vertex_index, out_x, out_y, out_z, corner_first, corner_second, corner_third
  output logic [tms_pkg::OUT_DW-1:0]         m_axis_tdata,
  // is_face
  output logic                               m_axis_tuser,
  output logic                               m_axis_tlast
);
  import tms_pkg::*;

  vec_t          verts_q [NUM_VERTS];
  logic [IW-1:0] base_q;
  logic [3:0]    beat_q;
  logic          valid_q;
  logic          last_c;
  logic [1:0]    fsel;

  assign last_c = (beat_q == 4'(NUM_BEATS - 1));
  assign ready_o = !valid_q || (last_c && m_axis_tready);
  assign fsel = 2'(beat_q - 4'(NUM_VERTS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      beat_q <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      beat_q <= '0;
    end else if (valid_q && m_axis_tready) begin
      if (last_c) valid_q <= 1'b0;
      beat_q <= beat_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      verts_q <= verts_i;
      base_q <= base_i;
    end
  end

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tuser = 1'b0;
    if (beat_q < 4'(NUM_VERTS)) begin
      m_axis_tdata[18:0] = base_q + IW'(beat_q) + 1'b1;
      m_axis_tdata[38:19] = verts_q[beat_q[2:0]][0];
      m_axis_tdata[58:39] = verts_q[beat_q[2:0]][1];
      m_axis_tdata[78:59] = verts_q[beat_q[2:0]][2];
    end else begin
      m_axis_tuser = 1'b1;
      m_axis_tdata[97:79] = base_q + IW'(FACE_TBL[fsel][0]);
      m_axis_tdata[116:98] = base_q + IW'(FACE_TBL[fsel][1]);
      m_axis_tdata[135:117] = base_q + IW'(FACE_TBL[fsel][2]);
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tlast = last_c;

endmodule
`default_nettype wire

FILE: rtl/triangle_midpoint_subdivision.sv
// triangle midpoint subdivision
// input channel s_axis: one beat per triangle, number and three vertices a, b, c
// output channel m_axis: ten beats per triangle, six vertex beats (a, b, c and
// midpoints ab, ac, bc) then four face beats; tuser marks faces, tlast the tenth
// config channel cfg_*: one bit, normalise enable, reset value 1, always ready
// six normaliser lanes work on the six vertices of one triangle together; each
// lane forms the squared length, takes a two-bit-per-cycle square root and
// runs three two-bit-per-cycle dividers
// the triangle number is reduced by a reciprocal multiply, a back multiply and
// one compare and subtract, one register stage each
// with normalising on, the lanes square, sum, take the root, divide and finish;
// with it off they pass the vertices straight through; the output buffer is
// loaded once all lanes and the triangle number reduction are done
// the next triangle is taken while the ten beats of the previous one drain
// a stalled receiver holds the current beat; the lanes then wait with their
// results and s_axis_tready stays low until the output buffer frees
// reset empties all stages and sets normalise enable
`default_nettype none
module triangle_midpoint_subdivision #(
  parameter int MAX_TRIANGLES = tms_pkg::MAX_TRIANGLES_DEF,
  parameter int FRAC_BITS = tms_pkg::FRAC_BITS_DEF
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         s_axis_tvalid,
  output logic                        s_axis_tready,
  // triangle_number, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, zero pad
  input  wire  [tms_pkg::IN_DW-1:0]   s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire                         m_axis_tready,
  // vertex_index, out_x, out_y, out_z, corner_first, corner_second, corner_third
  output logic [tms_pkg::OUT_DW-1:0]  m_axis_tdata,
  // is_face
  output logic                        m_axis_tuser,
  output logic                        m_axis_tlast,
  input  wire                         cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire  [0:0]                  cfg_data_i
);
  import tms_pkg::*;

  localparam int MOD_CYC = 3;
  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / MAX_TRIANGLES);
  localparam logic [20:0] MOD_M = 21'(MAX_TRIANGLES);

  logic            norm_q;
  logic            pend_q;
  logic            mod_busy_q;
  logic [2:0]      mod_cnt_q;
  logic [TNW-1:0]  tn_q, quo_q, quo_d, mrem_q, mrem_d;
  logic [TNW:0]    rraw_q, rraw_d;
  logic            accept, load, merge_ready;
  logic [NUM_LANES-1:0] lane_done;
  vec_t            vin [NUM_VERTS];
  vec_t            vout [NUM_VERTS];
  lane_ctl_t       lane_ctl;
  logic [IW-1:0]   base;

  assign cfg_ready_o = 1'b1;
  assign s_axis_tready = !pend_q;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign load = pend_q && (&lane_done) && !mod_busy_q && merge_ready;

  always_comb begin
    logic signed [CW:0] sum;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        vin[k][j] = s_axis_tdata[TNW + (3 * k + j) * CW +: CW];
      end
    end
    for (int j = 0; j < 3; j++) begin
      sum = $signed({vin[0][j][CW-1], vin[0][j]}) + $signed({vin[1][j][CW-1], vin[1][j]});
      vin[3][j] = sum[CW:1];
      sum = $signed({vin[0][j][CW-1], vin[0][j]}) + $signed({vin[2][j][CW-1], vin[2][j]});
      vin[4][j] = sum[CW:1];
      sum = $signed({vin[1][j][CW-1], vin[1][j]}) + $signed({vin[2][j][CW-1], vin[2][j]});
      vin[5][j] = sum[CW:1];
    end
  end

  assign lane_ctl.start = accept;
  assign lane_ctl.ack = load;
  assign lane_ctl.norm_en = norm_q;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    tms_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (lane_ctl),
      .vec_i  (vin[g]),
      .done_o (lane_done[g]),
      .vec_o  (vout[g])
    );
  end

  // estimated quotient is the true one or one less
  always_comb begin
    logic [TNW+32:0] prod_v;
    logic [TNW+20:0] qm_v;
    logic [20:0]     r_v;
    prod_v = {33'd0, tn_q} * {16'd0, RECIP};
    quo_d = prod_v[TNW+31:32];
    qm_v = {21'd0, quo_q} * {16'd0, MOD_M};
    rraw_d = {1'b0, tn_q} - qm_v[TNW:0];
    r_v = {4'd0, rraw_q};
    mrem_d = (r_v >= MOD_M) ? TNW'(r_v - MOD_M) : rraw_q[TNW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norm_q <= 1'b1;
      pend_q <= 1'b0;
      mod_busy_q <= 1'b0;
      mod_cnt_q <= '0;
    end else begin
      if (cfg_valid_i) norm_q <= cfg_data_i[0];
      if (accept) pend_q <= 1'b1;
      else if (load) pend_q <= 1'b0;
      if (accept) begin
        mod_busy_q <= 1'b1;
        mod_cnt_q <= '0;
      end else if (mod_busy_q) begin
        mod_cnt_q <= mod_cnt_q + 1'b1;
        if (mod_cnt_q == 3'(MOD_CYC - 1)) mod_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tn_q <= s_axis_tdata[TNW-1:0];
    end else if (mod_busy_q) begin
      quo_q <= quo_d;
      rraw_q <= rraw_d;
      mrem_q <= mrem_d;
    end
  end

  assign base = IW'({3'b000, mrem_q} * 19'd6);

  tms_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .verts_i       (vout),
    .base_i        (base),
    .ready_o       (merge_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import tms_pkg::*;

  typedef struct packed {
    logic          face;
    logic [IW-1:0] vidx;
    logic [CW-1:0] x, y, z;
    logic [IW-1:0] c1, c2, c3;
    logic          last;
  } subdiv_rec_t;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [IN_DW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [OUT_DW-1:0] m_axis_tdata;
  logic m_axis_tuser, m_axis_tlast;
  logic cfg_valid_i = 0;
  logic cfg_ready_o;
  logic [0:0] cfg_data_i = '0;

  subdiv_rec_t expected_recs[$];
  int mismatches = 0;
  logic norm_on = 1;
  int stall_mode = 0;

  always #4 clk_i = ~clk_i;

  triangle_midpoint_subdivision uut (.*);

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned mag_of(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic logic [CW-1:0] scale_coord(longint v, longint unsigned r);
    longint unsigned q;
    if (r == 0) return '0;
    q = (mag_of(v) << FRAC_BITS_DEF) / r;
    if (q > COORD_MAX) q = COORD_MAX;
    return v < 0 ? CW'(-longint'(q)) : CW'(q);
  endfunction

  function automatic subdiv_rec_t vertex_rec(longint unsigned idx, longint p[3]);
    subdiv_rec_t rec;
    longint unsigned s, r;
    rec = '0;
    rec.vidx = IW'(idx);
    if (norm_on) begin
      s = mag_of(p[0]) * mag_of(p[0]) + mag_of(p[1]) * mag_of(p[1])
        + mag_of(p[2]) * mag_of(p[2]);
      r = int_sqrt(s);
      rec.x = scale_coord(p[0], r);
      rec.y = scale_coord(p[1], r);
      rec.z = scale_coord(p[2], r);
    end else begin
      rec.x = CW'(p[0]);
      rec.y = CW'(p[1]);
      rec.z = CW'(p[2]);
    end
    return rec;
  endfunction

  function automatic subdiv_rec_t face_rec(longint unsigned a, b, c);
    subdiv_rec_t rec;
    rec = '0;
    rec.face = 1;
    rec.c1 = IW'(a);
    rec.c2 = IW'(b);
    rec.c3 = IW'(c);
    return rec;
  endfunction

  task automatic predict_subdivision(logic [TNW-1:0] tnum, logic [8:0][CW-1:0] crd);
    longint v[6][3];
    longint p[3];
    longint unsigned base;
    subdiv_rec_t rec;
    base = (longint'(tnum) % MAX_TRIANGLES_DEF) * 6;
    for (int k = 0; k < 3; k++)
      for (int j = 0; j < 3; j++) v[k][j] = longint'($signed(crd[k*3+j]));
    for (int j = 0; j < 3; j++) begin
      v[3][j] = (v[0][j] + v[1][j]) >>> 1;
      v[4][j] = (v[0][j] + v[2][j]) >>> 1;
      v[5][j] = (v[1][j] + v[2][j]) >>> 1;
    end
    for (int k = 0; k < 6; k++) begin
      p = v[k];
      expected_recs.insert(expected_recs.size(), vertex_rec(base + k + 1, p));
    end
    expected_recs.insert(expected_recs.size(), face_rec(base + 1, base + 4, base + 5));
    expected_recs.insert(expected_recs.size(), face_rec(base + 2, base + 6, base + 4));
    expected_recs.insert(expected_recs.size(), face_rec(base + 3, base + 5, base + 6));
    rec = face_rec(base + 4, base + 6, base + 5);
    rec.last = 1;
    expected_recs.insert(expected_recs.size(), rec);
  endtask

  function automatic int rand_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  task automatic send_triangle(logic [TNW-1:0] tnum, logic [8:0][CW-1:0] crd, bit gaps);
    int g;
    g = gaps ? rand_gap() : 0;
    if (g > 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tdata <= IN_DW'({crd, tnum});
    s_axis_tvalid <= 1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_subdivision(tnum, crd);
    @(negedge clk_i);
  endtask

  // receiver stalls
  always @(negedge clk_i) begin
    if (!rst_ni) m_axis_tready <= 0;
    else if (stall_mode == 0) m_axis_tready <= 1;
    else if ($urandom_range(0, 19) == 0) m_axis_tready <= 0;
    else if ($urandom_range(0, 2) == 0) m_axis_tready <= 1;
  end

  always @(posedge clk_i) begin
    subdiv_rec_t got, exp_rec;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '0;
      got.face = m_axis_tuser;
      got.last = m_axis_tlast;
      {got.c3, got.c2, got.c1, got.z, got.y, got.x, got.vidx} = m_axis_tdata[IW*4+CW*3-1:0];
      if (expected_recs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h", got);
      end else begin
        exp_rec = expected_recs.pop_front();
        if (got !== exp_rec) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: face %0b/%0b idx %0d/%0d xyz %h %h %h / %h %h %h c %0d %0d %0d / %0d %0d %0d last %0b/%0b",
              exp_rec.face, got.face, exp_rec.vidx, got.vidx, exp_rec.x, exp_rec.y, exp_rec.z,
              got.x, got.y, got.z, exp_rec.c1, exp_rec.c2, exp_rec.c3, got.c1, got.c2, got.c3,
              exp_rec.last, got.last);
        end
      end
    end
  end

  task automatic drain_pipe();
    s_axis_tvalid <= 0;
    while (expected_recs.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_norm(logic val);
    cfg_data_i <= val;
    cfg_valid_i <= 1;
    do @(posedge clk_i); while (!cfg_ready_o);
    norm_on = val;
    @(negedge clk_i);
    cfg_valid_i <= 0;
    @(negedge clk_i);
  endtask

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return CW'(20'h80000);
      1: return CW'(20'h7ffff);
      2: return CW'($urandom_range(0, 3) - 1);
      3: return CW'($urandom_range(0, 65536) - 32768);
      default: return CW'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    logic [8:0][CW-1:0] crd;
    for (int n = 0; n < 2; n++) begin
      crd = '0;
      send_triangle(16'd0, crd, 0);
      for (int i = 0; i < 9; i++) crd[i] = 20'h80000;
      send_triangle(16'hffff, crd, 0);
      for (int i = 0; i < 9; i++) crd[i] = 20'h7ffff;
      send_triangle(16'h8000, crd, 0);
      for (int i = 0; i < 9; i++) crd[i] = (i % 2) ? 20'h80000 : 20'h7ffff;
      send_triangle(16'h5555, crd, 0);
      for (int i = 0; i < 9; i++) crd[i] = (i % 3 == i / 3) ? 20'h10000 : 20'hfffff;
      send_triangle(16'haaaa, crd, 0);
      crd = '0;
      crd[1] = 20'd1;
      crd[3] = 20'hfffff;
      send_triangle(16'd1, crd, 0);
      drain_pipe();
      write_norm(~norm_on);
    end
  endtask

  task automatic test_random(int count, bit gaps);
    logic [8:0][CW-1:0] crd;
    for (int n = 0; n < count; n++) begin
      for (int i = 0; i < 9; i++) crd[i] = rand_coord();
      send_triangle(16'($urandom), crd, gaps);
    end
    drain_pipe();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);
    test_directed();
    test_random(30, 0);
    write_norm(0);
    stall_mode = 1;
    test_random(30, 1);
    write_norm(1);
    test_random(40, 1);
    write_norm(0);
    write_norm(1);
    stall_mode = 0;
    test_random(20, 1);
    drain_pipe();
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

FILE: files.f
rtl/tms_pkg.sv
rtl/tms_lane.sv
rtl/tms_merge.sv
rtl/triangle_midpoint_subdivision.sv
tb/testbench.sv
